>>> design/cnp_pkg.sv
// Package for the lexicographic next/previous combination block.
// Holds widths, codes and the per-lane flag type. No dependencies.
`timescale 1ns / 1ps

package cnp_pkg;

	localparam int FIELD_COUNT      = 8;
	localparam int MAX_ELEMENTS_DEF = 8;
	localparam int POS_W            = 8;
	localparam int W_W              = 9;
	localparam int N_W              = 4;
	localparam int IDX_W            = 3;
	localparam int CFG_IDX_W        = 1;

	// Largest usable number of positions.
	localparam logic [W_W-1:0] W_LIMIT = 9'd256;

	localparam logic [W_W-1:0] NUM_STATES_RST    = 9'd16;
	localparam logic [N_W-1:0] NUM_PARTICLES_RST = 4'd4;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTICLES = 1'b1;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic {
		OP_NEXT = 1'b0,
		OP_PREV = 1'b1
	} opcode_t;

	// What one lane reports about its element.
	typedef struct packed {
		logic fit;  // element can advance with room for all later ones
		logic brk;  // element does not follow its predecessor directly
	} lane_flags_t;

endpackage

>>> design/cnp_lane.sv
// One element lane: tests whether the element has room to advance and
// whether it breaks the consecutive run. Depends on cnp_pkg.
`timescale 1ns / 1ps

module cnp_lane import cnp_pkg::*; #(
	parameter int IDX = 0
) (
	input  pos_t             p_cur,
	input  pos_t             p_lo,
	input  logic [W_W-1:0]   w,
	input  logic [N_W-1:0]   n,
	output lane_flags_t      flags
);

	logic            active;
	logic [W_W:0]    need;

	always_comb begin
		active = N_W'(IDX) < n;
		// Element plus all later ones must stay at or below w-1.
		need = {2'b00, p_cur} + {6'd0, n} + 10'd1 - 10'(IDX);
		flags.fit = active && (need <= {1'b0, w});
		if (IDX == 0) begin
			flags.brk = 1'b0;
		end else begin
			flags.brk = active && (({1'b0, p_lo} + 9'd1) != {1'b0, p_cur});
		end
	end

endmodule

>>> design/cnp_merge.sv
// Merging stage: picks the pivot element from the lane flags and forms
// the new combination. Depends on cnp_pkg.
`timescale 1ns / 1ps

module cnp_merge import cnp_pkg::*; (
	input  opcode_t                  op,
	input  pos_t                     pos   [FIELD_COUNT],
	input  lane_flags_t              flags [FIELD_COUNT],
	input  logic [W_W-1:0]           w,
	input  logic [N_W-1:0]           n,
	output logic                     found,
	output pos_t                     res   [FIELD_COUNT]
);

	logic nxt_hit;
	idx_t nxt_idx;
	idx_t prv_idx;
	pos_t nxt_base;
	pos_t prv_base;

	always_comb begin
		nxt_hit = 1'b0;
		nxt_idx = '0;
		prv_idx = '0;
		// Ascending scan, so the highest flagged lane wins.
		for (int k = 0; k < FIELD_COUNT; k++) begin
			if (flags[k].fit) begin
				nxt_hit = 1'b1;
				nxt_idx = IDX_W'(k);
			end
			if (flags[k].brk) begin
				prv_idx = IDX_W'(k);
			end
		end
		nxt_base = pos[nxt_idx];
		prv_base = pos[prv_idx];

		if (op == OP_NEXT) begin
			found = nxt_hit;
		end else begin
			found = (n != '0) && !((prv_idx == '0) && (pos[0] == '0));
		end

		for (int j = 0; j < FIELD_COUNT; j++) begin
			res[j] = pos[j];
			if (found && (N_W'(j) < n)) begin
				if (op == OP_NEXT) begin
					if (IDX_W'(j) >= nxt_idx) begin
						res[j] = nxt_base + POS_W'(j) - POS_W'(nxt_idx) + 8'd1;
					end
				end else begin
					if (IDX_W'(j) == prv_idx) begin
						res[j] = prv_base - 8'd1;
					end else if (IDX_W'(j) > prv_idx) begin
						// Later elements take the highest positions.
						res[j] = w[POS_W-1:0] - POS_W'(n) + POS_W'(j);
					end
				end
			end
		end
	end

endmodule

>>> design/combination_next_previous.sv
// Pipeline: an accepted input transaction is registered in stage one, and its result in stage two.
// Throughput: one transaction per cycle while out_ready is high; eight element lanes run side by
// side in the first stage and the merging stage selects the pivot in the second.
// Reset clears both pipeline valid flags and loads num_states = 16 and
// num_particles = 4; no clearing pass is needed.
`timescale 1ns / 1ps

module combination_next_previous import cnp_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W_W-1:0]       cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  pos_t                 in_pos_0,
	input  pos_t                 in_pos_1,
	input  pos_t                 in_pos_2,
	input  pos_t                 in_pos_3,
	input  pos_t                 in_pos_4,
	input  pos_t                 in_pos_5,
	input  pos_t                 in_pos_6,
	input  pos_t                 in_pos_7,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output pos_t                 out_pos_0,
	output pos_t                 out_pos_1,
	output pos_t                 out_pos_2,
	output pos_t                 out_pos_3,
	output pos_t                 out_pos_4,
	output pos_t                 out_pos_5,
	output pos_t                 out_pos_6,
	output pos_t                 out_pos_7
);

	logic [W_W-1:0] num_states_q;
	logic [N_W-1:0] num_particles_q;
	logic [W_W-1:0] w_eff;
	logic [N_W-1:0] n_eff;

	pos_t        in_pos   [FIELD_COUNT];
	lane_flags_t lane_fl  [FIELD_COUNT];

	logic        valid_s1;
	opcode_t     op_s1;
	pos_t        pos_s1   [FIELD_COUNT];
	lane_flags_t flags_s1 [FIELD_COUNT];
	logic [W_W-1:0] w_s1;
	logic [N_W-1:0] n_s1;

	logic        mrg_found;
	pos_t        mrg_res  [FIELD_COUNT];

	logic        valid_s2;
	logic        found_s2;
	pos_t        pos_s2   [FIELD_COUNT];

	logic        s1_en;
	logic        s2_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q    <= NUM_STATES_RST;
			num_particles_q <= NUM_PARTICLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_STATES:    num_states_q    <= cfg_data;
				REG_NUM_PARTICLES: num_particles_q <= cfg_data[N_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (num_states_q > W_LIMIT) ? W_LIMIT : num_states_q;
	assign n_eff = (num_particles_q > N_W'(MAX_ELEMENTS)) ? N_W'(MAX_ELEMENTS)
		: num_particles_q;

	assign in_pos[0] = in_pos_0;
	assign in_pos[1] = in_pos_1;
	assign in_pos[2] = in_pos_2;
	assign in_pos[3] = in_pos_3;
	assign in_pos[4] = in_pos_4;
	assign in_pos[5] = in_pos_5;
	assign in_pos[6] = in_pos_6;
	assign in_pos[7] = in_pos_7;

	for (genvar g = 0; g < FIELD_COUNT; g++) begin : g_lane
		cnp_lane #(.IDX(g)) u_lane (
			.p_cur (in_pos[g]),
			.p_lo  (in_pos[(g == 0) ? 0 : g - 1]),
			.w     (w_eff),
			.n     (n_eff),
			.flags (lane_fl[g])
		);
	end

	// Each stage moves on when the stage after it is empty or draining.
	assign s2_en    = !valid_s2 || out_ready;
	assign s1_en    = !valid_s1 || s2_en;
	assign in_ready = s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= in_valid;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && in_valid) begin
			op_s1    <= opcode_t'(opcode);
			pos_s1   <= in_pos;
			flags_s1 <= lane_fl;
			w_s1     <= w_eff;
			n_s1     <= n_eff;
		end
	end

	cnp_merge u_merge (
		.op    (op_s1),
		.pos   (pos_s1),
		.flags (flags_s1),
		.w     (w_s1),
		.n     (n_s1),
		.found (mrg_found),
		.res   (mrg_res)
	);

	always_ff @(posedge clk) begin
		if (s2_en && valid_s1) begin
			found_s2 <= mrg_found;
			pos_s2   <= mrg_res;
		end
	end

	assign out_valid = valid_s2;
	assign found     = found_s2;
	assign out_pos_0 = pos_s2[0];
	assign out_pos_1 = pos_s2[1];
	assign out_pos_2 = pos_s2[2];
	assign out_pos_3 = pos_s2[3];
	assign out_pos_4 = pos_s2[4];
	assign out_pos_5 = pos_s2[5];
	assign out_pos_6 = pos_s2[6];
	assign out_pos_7 = pos_s2[7];

endmodule

>>> design/cnp_checker.sv
// Port-level checks for the combination block, bound to the top level.
// Depends on cnp_pkg and combination_next_previous.
`timescale 1ns / 1ps

module cnp_checker import cnp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input pos_t out_pos_0,
	input pos_t out_pos_7
);

	// The input side only stalls when a result is waiting at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// With the output draining, an accepted transaction passes through both pipeline registers to the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("result missing two cycles after input transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(found)
			&& $stable(out_pos_0) && $stable(out_pos_7)))
		else $error("stalled result changed");

endmodule

bind combination_next_previous cnp_checker u_cnp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found),
	.out_pos_0 (out_pos_0),
	.out_pos_7 (out_pos_7)
);

>>> dv/tb.sv
// Self-checking testbench for combination_next_previous (lexicographic next/previous step).
// Depends on cnp_pkg and the block's RTL; builds expected results from its own step predictor.
`timescale 1ns / 1ps

module tb;
	import cnp_pkg::*;

	typedef struct packed {
		opcode_t                   op;
		pos_t [FIELD_COUNT-1:0]    pos;
	} comb_item_t;

	typedef struct packed {
		logic                      found;
		pos_t [FIELD_COUNT-1:0]    pos;
	} comb_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [W_W-1:0]       cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 opcode = 1'b0;
	pos_t                 in_pos_0 = '0;
	pos_t                 in_pos_1 = '0;
	pos_t                 in_pos_2 = '0;
	pos_t                 in_pos_3 = '0;
	pos_t                 in_pos_4 = '0;
	pos_t                 in_pos_5 = '0;
	pos_t                 in_pos_6 = '0;
	pos_t                 in_pos_7 = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 found;
	pos_t                 out_pos_0;
	pos_t                 out_pos_1;
	pos_t                 out_pos_2;
	pos_t                 out_pos_3;
	pos_t                 out_pos_4;
	pos_t                 out_pos_5;
	pos_t                 out_pos_6;
	pos_t                 out_pos_7;

	comb_result_t  awaited_steps[$];
	int unsigned   model_num_states = NUM_STATES_RST;
	int unsigned   model_num_particles = NUM_PARTICLES_RST;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            mismatch_count = 0;

	combination_next_previous dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .opcode,
		.in_pos_0, .in_pos_1, .in_pos_2, .in_pos_3,
		.in_pos_4, .in_pos_5, .in_pos_6, .in_pos_7,
		.out_valid, .out_ready, .found,
		.out_pos_0, .out_pos_1, .out_pos_2, .out_pos_3,
		.out_pos_4, .out_pos_5, .out_pos_6, .out_pos_7
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Works out the lexicographic neighbour of one combination under the given registers.
	function automatic comb_result_t step_combination(comb_item_t item, int unsigned w_reg,
			int unsigned n_reg);
		int           w;
		int           n;
		int           i;
		int           j;
		int           base;
		int           fill;
		int           p[FIELD_COUNT];
		bit           ok;
		comb_result_t r;
		w = (w_reg > 256) ? 256 : int'(w_reg);
		n = (n_reg > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(n_reg);
		for (int k = 0; k < FIELD_COUNT; k++)
			p[k] = int'(item.pos[k]);
		ok = 1'b0;
		if (n > 0 && item.op == OP_NEXT) begin
			i = n - 1;
			while (i >= 0 && !ok) begin
				if ((w - 1 - p[i]) >= (n - i)) begin
					base = p[i];
					for (j = i; j < n; j++)
						p[j] = base + (j - i) + 1;
					ok = 1'b1;
				end else begin
					i--;
				end
			end
		end else if (n > 0) begin
			i = n - 1;
			while (i > 0 && p[i - 1] + 1 == p[i])
				i--;
			if (!(i == 0 && p[0] == 0)) begin
				p[i] = p[i] - 1;
				fill = w - 1;
				for (j = n - 1; j > i; j--) begin
					p[j] = fill;
					fill--;
				end
				ok = 1'b1;
			end
		end
		r.found = ok;
		for (int k = 0; k < FIELD_COUNT; k++)
			r.pos[k] = ok ? pos_t'(p[k]) : item.pos[k];
		return r;
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Inputs only move at rising edges, so the handshake seen at the falling edge is the one
	// that the next rising edge takes.
	always @(negedge clk) begin
		comb_result_t got;
		comb_result_t want;
		bit           bad;
		if (arst_n && out_valid && out_ready) begin
			got.found = found;
			got.pos = {out_pos_7, out_pos_6, out_pos_5, out_pos_4,
				out_pos_3, out_pos_2, out_pos_1, out_pos_0};
			if (awaited_steps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transaction: found %0b pos %h",
						got.found, got.pos);
			end else begin
				want = awaited_steps.pop_front();
				bad = (got.found !== want.found);
				for (int k = 0; k < FIELD_COUNT; k++)
					if (got.pos[k] !== want.pos[k])
						bad = 1'b1;
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected found %0b pos %h, got found %0b pos %h",
							want.found, want.pos, got.found, got.pos);
				end
			end
		end
	end

	task automatic send_item(comb_item_t it);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= it.op;
		in_pos_0 <= it.pos[0];
		in_pos_1 <= it.pos[1];
		in_pos_2 <= it.pos[2];
		in_pos_3 <= it.pos[3];
		in_pos_4 <= it.pos[4];
		in_pos_5 <= it.pos[5];
		in_pos_6 <= it.pos[6];
		in_pos_7 <= it.pos[7];
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		awaited_steps.push_back(step_combination(it, model_num_states, model_num_particles));
	endtask

	task automatic send_positions(opcode_t op, int a0, int a1, int a2, int a3,
			int a4, int a5, int a6, int a7);
		comb_item_t it;
		it.op = op;
		it.pos = {pos_t'(a7), pos_t'(a6), pos_t'(a5), pos_t'(a4),
			pos_t'(a3), pos_t'(a2), pos_t'(a1), pos_t'(a0)};
		send_item(it);
	endtask

	// Leaves the input channel idle until every result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_steps.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W_W-1:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		if (idx == REG_NUM_STATES)
			model_num_states = data;
		else
			model_num_particles = data[N_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [W_W-1:0] w, logic [W_W-1:0] n);
		drain_results();
		write_reg(REG_NUM_STATES, w);
		write_reg(REG_NUM_PARTICLES, n);
	endtask

	// Mostly valid combinations for the current registers, packed low, packed high or spread,
	// so that the first and last combinations turn up often; the rest is noise.
	function automatic comb_item_t random_combination();
		comb_item_t it;
		int         weff;
		int         neff;
		int         lo;
		int         hi;
		int         style;
		int         pick;
		int         pos;
		weff = (model_num_states > 256) ? 256 : int'(model_num_states);
		neff = (model_num_particles > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF
			: int'(model_num_particles);
		it.op = opcode_t'($urandom_range(1));
		for (int k = 0; k < FIELD_COUNT; k++)
			it.pos[k] = pos_t'($urandom_range(255));
		if ($urandom_range(99) >= 15 && neff > 0 && weff >= neff) begin
			style = $urandom_range(3);
			lo = 0;
			for (int k = 0; k < neff; k++) begin
				hi = weff - (neff - k);
				pick = (style == 3) ? $urandom_range(2) : style;
				case (pick)
					0: pos = $urandom_range(hi, lo);
					1: pos = lo;
					default: pos = hi;
				endcase
				it.pos[k] = pos_t'(pos);
				lo = pos + 1;
			end
		end
		return it;
	endfunction

	task automatic test_reset_settings();
		send_positions(OP_NEXT, 0, 1, 2, 3, 255, 0, 170, 85);
		send_positions(OP_NEXT, 0, 1, 14, 15, 0, 255, 85, 170);
		send_positions(OP_NEXT, 12, 13, 14, 15, 1, 2, 4, 8);
		send_positions(OP_PREV, 12, 13, 14, 15, 16, 32, 64, 128);
		send_positions(OP_PREV, 0, 1, 2, 3, 127, 254, 253, 251);
		send_positions(OP_PREV, 0, 1, 2, 9, 247, 239, 223, 191);
	endtask

	task automatic test_count_and_width_extremes();
		// With no elements in use nothing moves.
		set_config(9'd16, 9'd0);
		send_positions(OP_NEXT, 0, 1, 2, 3, 4, 5, 6, 7);
		send_positions(OP_PREV, 3, 4, 5, 6, 7, 8, 9, 10);
		set_config(9'd256, 9'd8);
		send_positions(OP_NEXT, 248, 249, 250, 251, 252, 253, 254, 255);
		send_positions(OP_PREV, 248, 249, 250, 251, 252, 253, 254, 255);
		send_positions(OP_NEXT, 0, 1, 2, 3, 4, 5, 6, 7);
		send_positions(OP_PREV, 0, 1, 2, 3, 4, 5, 6, 7);
		send_positions(OP_NEXT, 0, 50, 100, 150, 200, 250, 254, 255);
		// An oversized count acts as eight elements and an oversized width as 256.
		set_config(9'd511, 9'd15);
		send_positions(OP_NEXT, 0, 1, 2, 3, 4, 5, 6, 255);
		send_positions(OP_PREV, 1, 2, 3, 4, 5, 6, 7, 8);
		// With no positions next has no room, while previous fills from a wrapped top.
		set_config(9'd0, 9'd2);
		send_positions(OP_NEXT, 0, 1, 9, 9, 9, 9, 9, 9);
		send_positions(OP_PREV, 3, 7, 9, 9, 9, 9, 9, 9);
		send_positions(OP_PREV, 5, 6, 9, 9, 9, 9, 9, 9);
		set_config(9'd1, 9'd1);
		send_positions(OP_NEXT, 0, 200, 100, 50, 25, 12, 6, 3);
		send_positions(OP_PREV, 0, 200, 100, 50, 25, 12, 6, 3);
	endtask

	task automatic test_malformed_input();
		// Out of order or out of range positions, including a decrement below zero.
		set_config(9'd16, 9'd3);
		send_positions(OP_NEXT, 9, 4, 200, 0, 0, 0, 0, 0);
		send_positions(OP_PREV, 3, 0, 0, 0, 0, 0, 0, 0);
		send_positions(OP_PREV, 0, 0, 1, 0, 0, 0, 0, 0);
		send_positions(OP_NEXT, 255, 255, 255, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random_phase(int idle_pct, int stall_pct, int items);
		int w;
		int n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int blk = 0; blk < items / 100; blk++) begin
			case ($urandom_range(9))
				0: w = 1;
				1: w = 256;
				2: w = $urandom_range(511, 257);
				3: w = $urandom_range(8, 2);
				default: w = $urandom_range(64, 8);
			endcase
			case ($urandom_range(9))
				0: n = 0;
				1: n = 8;
				2: n = $urandom_range(15, 9);
				default: n = $urandom_range(8, 1);
			endcase
			// Upper data bits are junk for the four-bit count register.
			set_config(w[W_W-1:0], {5'($urandom), 4'(n)});
			for (int i = 0; i < 100; i++) begin
				send_item(random_combination());
				if (i == 50 && blk == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_count_and_width_extremes();
		test_malformed_input();
		test_random_phase(0, 0, 500);
		test_random_phase(71, 0, 500);
		test_random_phase(0, 71, 500);
		test_random_phase(23, 23, 500);
		drain_results();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> combination_next_previous.f
design/cnp_pkg.sv
design/cnp_lane.sv
design/cnp_merge.sv
design/combination_next_previous.sv
design/cnp_checker.sv
dv/tb.sv
